/* rtl/spiee_pkg.sv */
// ----------------------------------------------------------------------------
// SPI EEPROM command engine package
// Command codes, status bit positions and the SPI event codes.
// ----------------------------------------------------------------------------
package spiee_pkg;

    // SPI event carried by one input transfer
    typedef enum logic [1:0] {
        OP_SELECT    = 2'd0,
        OP_SHIFT_IN  = 2'd1,
        OP_SHIFT_OUT = 2'd2
    } op_t;

    // command bytes
    localparam logic [7:0] CMD_WRSR  = 8'd1;
    localparam logic [7:0] CMD_WRITE = 8'd2;
    localparam logic [7:0] CMD_READ  = 8'd3;
    localparam logic [7:0] CMD_WRDI  = 8'd4;
    localparam logic [7:0] CMD_RDSR  = 8'd5;
    localparam logic [7:0] CMD_WREN  = 8'd6;

    // write enable latch position in the status byte
    localparam int unsigned WEL_BIT = 1;

    // byte position within a command frame, saturating
    localparam logic [2:0] POS_CMD  = 3'd0;
    localparam logic [2:0] POS_HI   = 3'd1;
    localparam logic [2:0] POS_LO   = 3'd2;
    localparam logic [2:0] POS_DATA = 3'd3;
    localparam logic [2:0] POS_MAX  = 3'd4;

endpackage

/* rtl/spiee_in_if.sv */
// ----------------------------------------------------------------------------
// SPI event channel
// Valid/ready channel carrying one SPI event per transfer.
// ----------------------------------------------------------------------------
interface spiee_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       select_high;
    logic [7:0] tx_byte;

    modport source (output valid, output opcode, output select_high, output tx_byte,
                    input ready);
    modport sink (input valid, input opcode, input select_high, input tx_byte,
                  output ready);
endinterface

/* rtl/spiee_out_if.sv */
// ----------------------------------------------------------------------------
// SPI result channel
// Valid/ready channel carrying one result byte per transfer.
// ----------------------------------------------------------------------------
interface spiee_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

/* rtl/spi_eeprom_command_engine.sv */
// ----------------------------------------------------------------------------
// SPI serial EEPROM command engine
// Pipeline: the result is registered in s1, then in the output register, after the
// input transfer; one event per cycle sustained while the result channel does not
// stall and no clearing pass runs, with at most one memory access per event.
// Reset: control state clears at once, then a clearing pass writes zero to all
// MEM_BYTES entries, one per cycle; item.ready stays low until the pass ends.
// ----------------------------------------------------------------------------
module spi_eeprom_command_engine #(
    parameter int unsigned MEM_BYTES = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    spiee_in_if.sink    item,
    spiee_out_if.source result
);

    localparam int unsigned AW = $clog2(MEM_BYTES);

    // (high byte * 256) mod MEM_BYTES, built at elaboration
    logic [AW-1:0] hi_tab [256];

    for (genvar g = 0; g < 256; g++)
    begin : g_hi_tab
        assign hi_tab[g] = AW'((g * 256) % MEM_BYTES);
    end

    // control state
    logic          sel_reg,    sel_next;
    logic [7:0]    cmd_reg,    cmd_next;
    logic [2:0]    pos_reg,    pos_next;
    logic [7:0]    status_reg, status_next;
    logic [AW-1:0] idx_reg,    idx_next;
    logic [AW-1:0] hmod_reg,   hmod_next;

    // clearing pass
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // result pipeline
    logic          s1_valid_reg;
    logic          s1_mem_reg,  s1_mem_next;
    logic [7:0]    s1_data_reg, s1_data_next;
    logic          out_valid_reg;
    logic [7:0]    out_data_reg;

    logic          accept;
    logic          s1_adv;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic [AW:0]   addr_sum;
    logic [AW-1:0] addr_red;
    logic [AW-1:0] idx_inc;
    logic          wel;

    assign s1_adv     = !out_valid_reg || result.ready;
    assign item.ready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign accept     = item.valid && item.ready;

    assign wel      = status_reg[spiee_pkg::WEL_BIT];
    assign addr_sum = (AW+1)'(hmod_reg) + (AW+1)'(item.tx_byte);
    assign addr_red = (addr_sum >= (AW+1)'(MEM_BYTES)) ?
                      AW'(addr_sum - (AW+1)'(MEM_BYTES)) : AW'(addr_sum);
    assign idx_inc  = (idx_reg == AW'(MEM_BYTES - 1)) ? '0 : idx_reg + AW'(1);

    always_comb
    begin
        sel_next     = sel_reg;
        cmd_next     = cmd_reg;
        pos_next     = pos_reg;
        status_next  = status_reg;
        idx_next     = idx_reg;
        hmod_next    = hmod_reg;
        s1_mem_next  = 1'b0;
        s1_data_next = 8'd0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        if (accept)
        begin
            unique case (item.opcode)
                spiee_pkg::OP_SELECT:
                begin
                    sel_next = !item.select_high;
                    if (item.select_high)
                    begin
                        pos_next  = spiee_pkg::POS_CMD;
                        idx_next  = '0;
                        hmod_next = '0;
                    end
                end
                spiee_pkg::OP_SHIFT_IN:
                begin
                    s1_data_next = item.tx_byte;
                    if (sel_reg)
                    begin
                        priority if (pos_reg == spiee_pkg::POS_CMD)
                        begin
                            cmd_next = item.tx_byte;
                            pos_next = spiee_pkg::POS_HI;
                            if (item.tx_byte == spiee_pkg::CMD_WREN)
                            begin
                                status_next[spiee_pkg::WEL_BIT] = 1'b1;
                                pos_next = spiee_pkg::POS_CMD;
                            end
                            else if (item.tx_byte == spiee_pkg::CMD_WRDI)
                            begin
                                status_next[spiee_pkg::WEL_BIT] = 1'b0;
                                pos_next = spiee_pkg::POS_CMD;
                            end
                        end
                        else if (pos_reg == spiee_pkg::POS_HI)
                        begin
                            pos_next = spiee_pkg::POS_LO;
                            if (cmd_reg == spiee_pkg::CMD_WRITE ||
                                cmd_reg == spiee_pkg::CMD_READ)
                            begin
                                hmod_next = hi_tab[item.tx_byte];
                            end
                            else if (cmd_reg == spiee_pkg::CMD_RDSR)
                            begin
                                pos_next = spiee_pkg::POS_CMD;
                            end
                            else if (cmd_reg == spiee_pkg::CMD_WRSR)
                            begin
                                if (wel)
                                begin
                                    status_next = item.tx_byte;
                                end
                                pos_next = spiee_pkg::POS_CMD;
                            end
                        end
                        else if (pos_reg == spiee_pkg::POS_LO)
                        begin
                            idx_next = addr_red;
                            pos_next = spiee_pkg::POS_DATA;
                        end
                        else
                        begin
                            pos_next = spiee_pkg::POS_MAX;
                            if (cmd_reg == spiee_pkg::CMD_WRITE)
                            begin
                                mem_we   = wel;
                                idx_next = idx_inc;
                            end
                            else if (pos_reg != spiee_pkg::POS_DATA)
                            begin
                                idx_next = idx_inc;
                            end
                        end
                    end
                end
                spiee_pkg::OP_SHIFT_OUT:
                begin
                    if (sel_reg)
                    begin
                        if (cmd_reg == spiee_pkg::CMD_READ && pos_reg == spiee_pkg::POS_MAX)
                        begin
                            mem_re      = 1'b1;
                            s1_mem_next = 1'b1;
                        end
                        else if (cmd_reg == spiee_pkg::CMD_RDSR)
                        begin
                            s1_data_next = status_reg;
                        end
                    end
                end
                default:
                begin
                    // unused event code: no effect, result 0
                end
            endcase
        end
    end

    assign ram_waddr = clr_busy_reg ? clr_addr_reg : idx_reg;
    assign ram_wdata = clr_busy_reg ? 8'd0 : item.tx_byte;

    spiee_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we || clr_busy_reg),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 1'b0;
            cmd_reg       <= 8'd0;
            pos_reg       <= spiee_pkg::POS_CMD;
            status_reg    <= 8'd0;
            idx_reg       <= '0;
            hmod_reg      <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg    <= sel_next;
            cmd_reg    <= cmd_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
            idx_reg    <= idx_next;
            hmod_reg   <= hmod_next;

            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MEM_BYTES - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mem_reg  <= s1_mem_next;
            s1_data_reg <= s1_data_next;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_data_reg <= s1_mem_reg ? ram_rdata : s1_data_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.data_byte = out_data_reg;

`ifndef SYNTHESIS
    a_write_needs_wel: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> wel && !clr_busy_reg)
        else $error("memory write without write enable latch");

    a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !item.ready)
        else $error("input transfer during clearing pass");

    a_read_reaches_s1: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> s1_valid_reg && s1_mem_reg)
        else $error("memory read lost between issue and result stage");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= spiee_pkg::POS_MAX)
        else $error("byte position beyond saturation");
`endif

endmodule

/* rtl/spiee_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module spiee_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
